// ===== hw/rtl/skt_pkg.sv =====
package skt_pkg;

  // Sizes
  localparam int unsigned NumJoints    = 9;
  localparam int unsigned Slots        = 9;
  localparam int unsigned FracBits     = 16;
  localparam int unsigned CordicSteps  = 24;
  localparam int unsigned CordicStages = CordicSteps / 2;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 36;
  // angle reduction (2) + CORDIC stages + CORDIC rounding stage
  localparam int unsigned SideDepth    = 2 + CordicStages + 1;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegMode     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegYOff     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegZOff     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegToolOff  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegAxisMap  = 3'd4;

  localparam logic [35:0] AxisMapReset = 36'h876543210;

  // Request kinds
  localparam logic KindForward = 1'b0;
  localparam logic KindInverse = 1'b1;

  // Angle reduction: degrees in 28 fraction bits
  localparam logic [16:0]        DegBias    = 17'd33120;  // 92 turns of 360
  localparam logic [13:0]        RecipK     = 14'd11650;  // floor(2^22 / 360)
  localparam logic signed [37:0] FullTurn   = 38'sd96636764160;
  localparam logic signed [37:0] HalfTurn   = 38'sd48318382080;
  localparam logic signed [37:0] QuarterTurn = 38'sd24159191040;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] value_in_0;
    logic signed [31:0] value_in_1;
    logic signed [31:0] value_in_2;
    logic signed [31:0] value_in_3;
    logic signed [31:0] value_in_4;
    logic signed [31:0] value_in_5;
    logic signed [31:0] value_in_6;
    logic signed [31:0] value_in_7;
    logic signed [31:0] value_in_8;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value_out_0;
    logic signed [31:0] value_out_1;
    logic signed [31:0] value_out_2;
    logic signed [31:0] value_out_3;
    logic signed [31:0] value_out_4;
    logic signed [31:0] value_out_5;
    logic signed [31:0] value_out_6;
    logic signed [31:0] value_out_7;
    logic signed [31:0] value_out_8;
  } out_item_t;

  // Data that travels beside the angle path
  typedef struct packed {
    logic                  kind;
    logic                  mode;
    logic [Slots-1:0][31:0] vals;  // raw values (trunnion) or routed values
  } side_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [37:0] z;
  } cordic_vec_t;

  // atan(2^-i) in degrees, 28 fraction bits
  function automatic logic signed [37:0] atan_deg(input logic [4:0] i);
    logic signed [37:0] a;
    case (i)
      5'd0:    a = 38'sd12079595520;
      5'd1:    a = 38'sd7131001626;
      5'd2:    a = 38'sd3767825416;
      5'd3:    a = 38'sd1912607013;
      5'd4:    a = 38'sd960014949;
      5'd5:    a = 38'sd480475470;
      5'd6:    a = 38'sd240296363;
      5'd7:    a = 38'sd120155514;
      5'd8:    a = 38'sd60078674;
      5'd9:    a = 38'sd30039451;
      5'd10:   a = 38'sd15019740;
      5'd11:   a = 38'sd7509872;
      5'd12:   a = 38'sd3754936;
      5'd13:   a = 38'sd1877468;
      5'd14:   a = 38'sd938734;
      5'd15:   a = 38'sd469367;
      5'd16:   a = 38'sd234684;
      5'd17:   a = 38'sd117342;
      5'd18:   a = 38'sd58671;
      5'd19:   a = 38'sd29335;
      5'd20:   a = 38'sd14668;
      5'd21:   a = 38'sd7334;
      5'd22:   a = 38'sd3667;
      5'd23:   a = 38'sd1833;
      default: a = 38'sd0;
    endcase
    return a;
  endfunction

  // One CORDIC rotation step
  function automatic cordic_vec_t cordic_iter(input cordic_vec_t v, input logic [4:0] i);
    cordic_vec_t        r;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    dx = v.y >>> i;
    dy = v.x >>> i;
    if (!v.z[37]) begin
      r.x = v.x - dx;
      r.y = v.y + dy;
      r.z = v.z - atan_deg(i);
    end else begin
      r.x = v.x + dx;
      r.y = v.y - dy;
      r.z = v.z + atan_deg(i);
    end
    return r;
  endfunction

  // Product with a 2.28 factor, rounded half up (floor of p*q + 2^27 over 2^28)
  function automatic logic signed [37:0] mulq(input logic signed [33:0] p,
                                               input logic signed [31:0] q);
    logic signed [65:0] prod;
    prod = p * q;
    prod = prod + 66'sd134217728;
    return prod[65:28];
  endfunction

  // Clamp to the signed 32-bit range
  function automatic logic [31:0] sat32(input logic signed [41:0] v);
    logic [31:0] r;
    if (v > 42'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -42'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/switchable_trunnion_kinematics_unit.sv =====
// Switchable XYZAC trunnion kinematics unit.
// Input channel in_valid_i/in_ready_o/in_data_i carries one request: a kind
// (forward: joints to pose, inverse: pose to joints) and nine Q15.16 values.
// Output channel out_valid_o/out_ready_i/out_data_o returns one result of
// nine Q15.16 values per request, in request order.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (0 mode, 1 Y offset, 2 Z offset, 3 tool offset, 4 axis map); write only
// while no transaction is in flight.
// Pipeline: angle reduction, the CORDIC (12 stages of two steps plus
// rounding), then products, sums and saturation. Throughput: one
// transaction per cycle while the receiver does not stall; the whole
// pipeline advances together.
// A stalled receiver holds the output register and freezes every stage, so
// in_ready_o drops only while a result waits and out_ready_i is low.
// Reset clears all valid bits and loads the register defaults: identity
// mode, zero offsets, axis map joint i to axis i.
module switchable_trunnion_kinematics_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  skt_pkg::in_item_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output skt_pkg::out_item_t                  out_data_o,
  input  logic                                cfg_we_i,
  input  logic [skt_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [skt_pkg::CfgDataW-1:0]        cfg_wdata_i
);

  // Configuration registers
  logic               mode_q;
  logic signed [31:0] y_off_q;
  logic signed [31:0] z_off_q;
  logic signed [31:0] tool_off_q;
  logic [35:0]        map_q;
  logic signed [32:0] dz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 1'b0;
      y_off_q    <= '0;
      z_off_q    <= '0;
      tool_off_q <= '0;
      map_q      <= skt_pkg::AxisMapReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        skt_pkg::RegMode:    mode_q     <= cfg_wdata_i[0];
        skt_pkg::RegYOff:    y_off_q    <= cfg_wdata_i[31:0];
        skt_pkg::RegZOff:    z_off_q    <= cfg_wdata_i[31:0];
        skt_pkg::RegToolOff: tool_off_q <= cfg_wdata_i[31:0];
        skt_pkg::RegAxisMap: map_q      <= cfg_wdata_i[35:0];
        default: ;
      endcase
    end
  end

  // Combined rotary center Z
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q <= '0;
    end else begin
      dz_q <= 33'(z_off_q) + 33'(tool_off_q);
    end
  end

  // Global advance: everything moves unless a result is held
  logic en;
  logic combine_valid;

  assign en         = !combine_valid || out_ready_i;
  assign in_ready_o = en;

  // Input values and axis-map routing
  logic [skt_pkg::Slots-1:0][31:0] in_vals;
  logic [skt_pkg::Slots-1:0][31:0] routed;
  logic [3:0]                      code;
  skt_pkg::side_t                  side_d;

  assign in_vals[0] = in_data_i.value_in_0;
  assign in_vals[1] = in_data_i.value_in_1;
  assign in_vals[2] = in_data_i.value_in_2;
  assign in_vals[3] = in_data_i.value_in_3;
  assign in_vals[4] = in_data_i.value_in_4;
  assign in_vals[5] = in_data_i.value_in_5;
  assign in_vals[6] = in_data_i.value_in_6;
  assign in_vals[7] = in_data_i.value_in_7;
  assign in_vals[8] = in_data_i.value_in_8;

  always_comb begin
    routed = '0;
    code   = '0;
    for (int i = 0; i < skt_pkg::NumJoints; i++) begin
      code = map_q[4*i +: 4];
      if (code < 4'(skt_pkg::Slots)) begin
        if (in_data_i.kind == skt_pkg::KindForward) begin
          routed[code] = in_vals[i];      // later joints win duplicates
        end else begin
          routed[i] = in_vals[code];
        end
      end
    end
    side_d.kind = in_data_i.kind;
    side_d.mode = mode_q;
    side_d.vals = mode_q ? in_vals : routed;
  end

  // Side data delay, aligned with the angle path
  skt_pkg::side_t               side_q [skt_pkg::SideDepth];
  logic [skt_pkg::SideDepth-1:0] side_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_valid_q <= '0;
    end else if (en) begin
      side_valid_q <= {side_valid_q[skt_pkg::SideDepth-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d;
      for (int s = 1; s < skt_pkg::SideDepth; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  // A tilt and C rotary angle paths
  logic signed [37:0] z_a, z_c;
  logic               flip_a, flip_c;
  logic signed [31:0] sin_a, cos_a, sin_c, cos_c;

  skt_angle u_angle_a (
    .clk_i  (clk_i),
    .en_i   (en),
    .deg_i  (in_data_i.value_in_3),
    .z_o    (z_a),
    .flip_o (flip_a)
  );

  skt_angle u_angle_c (
    .clk_i  (clk_i),
    .en_i   (en),
    .deg_i  (in_data_i.value_in_4),
    .z_o    (z_c),
    .flip_o (flip_c)
  );

  skt_cordic u_cordic_a (
    .clk_i  (clk_i),
    .en_i   (en),
    .z_i    (z_a),
    .flip_i (flip_a),
    .sin_o  (sin_a),
    .cos_o  (cos_a)
  );

  skt_cordic u_cordic_c (
    .clk_i  (clk_i),
    .en_i   (en),
    .z_i    (z_c),
    .flip_i (flip_c),
    .sin_o  (sin_c),
    .cos_o  (cos_c)
  );

  // Products, sums and output register
  skt_combine u_combine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (side_valid_q[skt_pkg::SideDepth-1]),
    .side_i  (side_q[skt_pkg::SideDepth-1]),
    .sin_a_i (sin_a),
    .cos_a_i (cos_a),
    .sin_c_i (sin_c),
    .cos_c_i (cos_c),
    .y_off_i (y_off_q),
    .dz_i    (dz_q),
    .valid_o (combine_valid),
    .data_o  (out_data_o)
  );

  assign out_valid_o = combine_valid;

endmodule

// ===== hw/rtl/skt_angle.sv =====
// Reduces a Q15.16 angle modulo 360 and folds it into [-90, 90] degrees.
module skt_angle (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] deg_i,
  output logic signed [37:0] z_o,
  output logic               flip_o
);

  logic [16:0] u_d, u_q;
  logic [7:0]  quo_d, quo_q;
  logic [15:0] frac_q;
  logic [17:0] ub;
  logic [30:0] prod;

  // Stage 1: bias to non-negative whole degrees, estimate quotient by 360
  always_comb begin
    ub    = 18'($signed(deg_i[31:skt_pkg::FracBits])) + 18'(skt_pkg::DegBias);
    u_d   = ub[16:0];
    prod  = 31'(u_d) * 31'(skt_pkg::RecipK);
    quo_d = prod[29:22];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_q    <= u_d;
      quo_q  <= quo_d;
      frac_q <= deg_i[skt_pkg::FracBits-1:0];
    end
  end

  // Stage 2: remainder with one correction, then fold
  logic [16:0]        rem;
  logic signed [37:0] zu;
  logic signed [37:0] z_d, z_q;
  logic               flip_d, flip_q;

  always_comb begin
    rem = u_q - 17'(quo_q) * 17'd360;
    if (rem >= 17'd360) begin
      rem = rem - 17'd360;
    end
    zu = {1'b0, rem[8:0], frac_q, 12'b0};
    if (zu > skt_pkg::HalfTurn) begin
      zu = zu - skt_pkg::FullTurn;
    end
    flip_d = 1'b0;
    z_d    = zu;
    if (zu > skt_pkg::QuarterTurn) begin
      z_d    = zu - skt_pkg::HalfTurn;
      flip_d = 1'b1;
    end else if (zu < -skt_pkg::QuarterTurn) begin
      z_d    = zu + skt_pkg::HalfTurn;
      flip_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_q    <= z_d;
      flip_q <= flip_d;
    end
  end

  assign z_o    = z_q;
  assign flip_o = flip_q;

endmodule

// ===== hw/rtl/skt_cordic.sv =====
// Pipelined CORDIC, two rotation steps per stage, then rounding to 2.28.
module skt_cordic (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [37:0] z_i,
  input  logic               flip_i,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);

  skt_pkg::cordic_vec_t vec_q  [skt_pkg::CordicStages];
  logic                 flip_q [skt_pkg::CordicStages];

  // Rotation stages
  for (genvar k = 0; k < skt_pkg::CordicStages; k++) begin : g_stage
    skt_pkg::cordic_vec_t vin;
    skt_pkg::cordic_vec_t vmid;
    skt_pkg::cordic_vec_t vout;
    logic                 fin;

    if (k == 0) begin : g_first
      assign vin.x = skt_pkg::CordicGain;
      assign vin.y = 34'sd0;
      assign vin.z = z_i;
      assign fin   = flip_i;
    end else begin : g_next
      assign vin = vec_q[k-1];
      assign fin = flip_q[k-1];
    end

    assign vmid = skt_pkg::cordic_iter(vin, 5'(2 * k));
    assign vout = skt_pkg::cordic_iter(vmid, 5'(2 * k + 1));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        vec_q[k]  <= vout;
        flip_q[k] <= fin;
      end
    end
  end

  // Round to 2.28 and undo the fold
  logic signed [33:0] xr;
  logic signed [33:0] yr;
  logic signed [31:0] sin_d, sin_q;
  logic signed [31:0] cos_d, cos_q;

  always_comb begin
    xr = vec_q[skt_pkg::CordicStages-1].x + 34'sd2;
    yr = vec_q[skt_pkg::CordicStages-1].y + 34'sd2;
    if (flip_q[skt_pkg::CordicStages-1]) begin
      sin_d = -yr[33:2];
      cos_d = -xr[33:2];
    end else begin
      sin_d = yr[33:2];
      cos_d = xr[33:2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

// ===== hw/rtl/skt_combine.sv =====
// Rotation products, term sums and saturation; last stage is the output register.
module skt_combine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  skt_pkg::side_t     side_i,
  input  logic signed [31:0] sin_a_i,
  input  logic signed [31:0] cos_a_i,
  input  logic signed [31:0] sin_c_i,
  input  logic signed [31:0] cos_c_i,
  input  logic signed [31:0] y_off_i,
  input  logic signed [32:0] dz_i,
  output logic               valid_o,
  output skt_pkg::out_item_t data_o
);

  logic [3:0] valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[2:0], valid_i};
    end
  end

  // Stage 1: trig cross products, centered coordinates
  skt_pkg::side_t     side1_q;
  logic signed [31:0] sa_q, ca_q, sc_q, cc_q;
  logic signed [31:0] s_ca_q, s_sa_q, c_ca_q, c_sa_q;
  logic signed [32:0] ry_q;
  logic signed [33:0] rz_q;
  logic signed [37:0] s_ca_w, s_sa_w, c_ca_w, c_sa_w;

  always_comb begin
    s_ca_w = skt_pkg::mulq(34'(sin_c_i), cos_a_i);
    s_sa_w = skt_pkg::mulq(34'(sin_c_i), sin_a_i);
    c_ca_w = skt_pkg::mulq(34'(cos_c_i), cos_a_i);
    c_sa_w = skt_pkg::mulq(34'(cos_c_i), sin_a_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side1_q <= side_i;
      sa_q    <= sin_a_i;
      ca_q    <= cos_a_i;
      sc_q    <= sin_c_i;
      cc_q    <= cos_c_i;
      s_ca_q  <= s_ca_w[31:0];
      s_sa_q  <= s_sa_w[31:0];
      c_ca_q  <= c_ca_w[31:0];
      c_sa_q  <= c_sa_w[31:0];
      ry_q    <= 33'($signed(side_i.vals[1])) - 33'(y_off_i);
      rz_q    <= 34'($signed(side_i.vals[2])) - 34'(dz_i);
    end
  end

  // Stage 2: rounded product terms, selected by kind
  skt_pkg::side_t     side2_q;
  logic signed [37:0] term_d [3][6];
  logic signed [37:0] term_q [3][6];
  logic signed [33:0] v0, v1, v2, dy, dz;

  always_comb begin
    v0 = 34'($signed(side1_q.vals[0]));
    v1 = 34'($signed(side1_q.vals[1]));
    v2 = 34'($signed(side1_q.vals[2]));
    dy = 34'(y_off_i);
    dz = 34'(dz_i);
    if (side1_q.kind == skt_pkg::KindForward) begin
      term_d[0][0] =  skt_pkg::mulq(v0, cc_q);
      term_d[0][1] =  skt_pkg::mulq(34'(ry_q), s_ca_q);
      term_d[0][2] =  skt_pkg::mulq(rz_q, s_sa_q);
      term_d[0][3] =  skt_pkg::mulq(dy, sc_q);
      term_d[0][4] =  38'sd0;
      term_d[0][5] =  38'sd0;
      term_d[1][0] = -skt_pkg::mulq(v0, sc_q);
      term_d[1][1] =  skt_pkg::mulq(34'(ry_q), c_ca_q);
      term_d[1][2] =  skt_pkg::mulq(rz_q, c_sa_q);
      term_d[1][3] =  skt_pkg::mulq(dy, cc_q);
      term_d[1][4] =  38'sd0;
      term_d[1][5] =  38'sd0;
      term_d[2][0] = -skt_pkg::mulq(34'(ry_q), sa_q);
      term_d[2][1] =  skt_pkg::mulq(rz_q, ca_q);
      term_d[2][2] =  38'(dz);
      term_d[2][3] =  38'sd0;
      term_d[2][4] =  38'sd0;
      term_d[2][5] =  38'sd0;
    end else begin
      term_d[0][0] =  skt_pkg::mulq(v0, cc_q);
      term_d[0][1] = -skt_pkg::mulq(v1, sc_q);
      term_d[0][2] =  38'sd0;
      term_d[0][3] =  38'sd0;
      term_d[0][4] =  38'sd0;
      term_d[0][5] =  38'sd0;
      term_d[1][0] =  skt_pkg::mulq(v0, s_ca_q);
      term_d[1][1] =  skt_pkg::mulq(v1, c_ca_q);
      term_d[1][2] = -skt_pkg::mulq(v2, sa_q);
      term_d[1][3] = -skt_pkg::mulq(dy, ca_q);
      term_d[1][4] =  skt_pkg::mulq(dz, sa_q);
      term_d[1][5] =  38'(dy);
      term_d[2][0] =  skt_pkg::mulq(v0, s_sa_q);
      term_d[2][1] =  skt_pkg::mulq(v1, c_sa_q);
      term_d[2][2] =  skt_pkg::mulq(v2, ca_q);
      term_d[2][3] = -skt_pkg::mulq(dy, sa_q);
      term_d[2][4] = -skt_pkg::mulq(dz, ca_q);
      term_d[2][5] =  38'(dz);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side2_q <= side1_q;
      term_q  <= term_d;
    end
  end

  // Stage 3: pairwise sums
  skt_pkg::side_t     side3_q;
  logic signed [41:0] pair_q [3][3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side3_q <= side2_q;
      for (int r = 0; r < 3; r++) begin
        for (int p = 0; p < 3; p++) begin
          pair_q[r][p] <= 42'(term_q[r][2*p]) + 42'(term_q[r][2*p+1]);
        end
      end
    end
  end

  // Stage 4: row totals, saturation, result assembly
  logic [31:0]        axis_sat [3];
  skt_pkg::out_item_t out_d, out_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      axis_sat[r] = skt_pkg::sat32(pair_q[r][0] + pair_q[r][1] + pair_q[r][2]);
    end
    if (side3_q.mode) begin
      out_d             = '0;
      out_d.value_out_0 = axis_sat[0];
      out_d.value_out_1 = axis_sat[1];
      out_d.value_out_2 = axis_sat[2];
      out_d.value_out_3 = side3_q.vals[3];
      out_d.value_out_4 = side3_q.vals[4];
    end else begin
      out_d.value_out_0 = side3_q.vals[0];
      out_d.value_out_1 = side3_q.vals[1];
      out_d.value_out_2 = side3_q.vals[2];
      out_d.value_out_3 = side3_q.vals[3];
      out_d.value_out_4 = side3_q.vals[4];
      out_d.value_out_5 = side3_q.vals[5];
      out_d.value_out_6 = side3_q.vals[6];
      out_d.value_out_7 = side3_q.vals[7];
      out_d.value_out_8 = side3_q.vals[8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  assign valid_o = valid_q[3];
  assign data_o  = out_q;

endmodule
